// ----- src/assert_macros.svh -----
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPLIES(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

// ----- src/lpm_pkg.sv -----
// ----------------------------------------------------------------------------
// lpm_pkg
// Shared types and constants of the longest prefix match table.
// ----------------------------------------------------------------------------
package lpm_pkg;
    localparam int ROUTES_DEF = 1024;
    localparam int PORTS_DEF  = 16;
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;
    localparam logic [31:0] TOP_BIT = 32'h8000_0000;

    // classified command handed from front to back
    typedef struct packed {
        logic        op;
        logic        drop;      // port out of range
        logic [5:0]  len;
        logic [31:0] pfx;       // masked prefix or lookup address
        logic [31:0] nh;
        logic [3:0]  port;
    } cmd_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] next_hop_out;
        logic [3:0]  port_out;
        logic        table_full;
    } res_t;

    function automatic logic [31:0] len_mask(input logic [5:0] len);
        logic [31:0] m;
        m = '0;
        for (int b = 0; b < 32; b++)
        begin
            if (32 - b <= int'(len))
                m[b] = 1'b1;
        end
        return m;
    endfunction

    // count the leading ones above the highest zero bit; all ones gives 32
    function automatic logic [5:0] lead_ones(input logic [31:0] m);
        logic [5:0] n;
        n = 6'd32;
        for (int b = 0; b < 32; b++)
        begin
            if (!m[b])
                n = 6'(31 - b);
        end
        return n;
    endfunction
endpackage

// ----- src/lpm_if.sv -----
// ----------------------------------------------------------------------------
// lpm_in_if / lpm_out_if
// Valid/ready channels of the table.
// ----------------------------------------------------------------------------
interface lpm_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] route_prefix;
    logic [31:0] route_mask;
    logic [31:0] next_hop_in;
    logic [3:0]  port_in;
    logic [31:0] lookup_addr;
    modport source (output valid, op, route_prefix, route_mask, next_hop_in, port_in,
                    lookup_addr, input ready);
    modport sink (input valid, op, route_prefix, route_mask, next_hop_in, port_in,
                  lookup_addr, output ready);
endinterface

interface lpm_out_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [31:0] next_hop_out;
    logic [3:0]  port_out;
    logic        table_full;
    modport source (output valid, hit, next_hop_out, port_out, table_full, input ready);
    modport sink (input valid, hit, next_hop_out, port_out, table_full, output ready);
endinterface

// ----- src/lpm_front.sv -----
// ----------------------------------------------------------------------------
// lpm_front
// Accepts transactions, derives prefix length and masked prefix, and queues
// the classified command (2-entry FIFO).
// ----------------------------------------------------------------------------
module lpm_front #(
    parameter int PORTS = lpm_pkg::PORTS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    lpm_in_if.sink         in,
    output logic           cmd_valid,
    input  logic           cmd_ready,
    output lpm_pkg::cmd_t  cmd
);
    lpm_pkg::cmd_t fifo_reg [2];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg;
    lpm_pkg::cmd_t c;
    logic          push, pop;

    always_comb
    begin
        c.op   = in.op;
        c.len  = lpm_pkg::lead_ones(in.route_mask);
        c.pfx  = (in.op == lpm_pkg::OP_LOOKUP) ? in.lookup_addr
                 : (in.route_prefix & lpm_pkg::len_mask(c.len));
        c.nh   = in.next_hop_in;
        c.port = in.port_in;
        c.drop = ({24'd0, in.port_in} >= 28'(PORTS));
    end

    assign in.ready  = (cnt_reg != 2'd2);
    assign push      = in.valid && in.ready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = fifo_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wp_reg] <= c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ----- src/lpm_back.sv -----
// ----------------------------------------------------------------------------
// lpm_back
// Executes commands by scanning the occupied slots, one per cycle, through
// the key and target memories.
// ----------------------------------------------------------------------------
module lpm_back #(
    parameter int ROUTES = lpm_pkg::ROUTES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  lpm_pkg::cmd_t  cmd,
    lpm_out_if.source      out,
    output logic           busy
);
    localparam int AW = (ROUTES > 1) ? $clog2(ROUTES) : 1;
    localparam int CW = $clog2(ROUTES + 1);
    localparam logic [1:0] S_IDLE = 2'd0, S_SCAN = 2'd1, S_FIN = 2'd2, S_OUT = 2'd3;

    logic [37:0]   key_mem [ROUTES];
    logic [35:0]   tgt_mem [ROUTES];
    logic [37:0]   key_rd;
    logic [35:0]   tgt_rd;

    logic [1:0]    state_reg;
    lpm_pkg::cmd_t cur_reg;
    logic [CW-1:0] count_reg, idx_reg;
    logic          rd_v_reg;       // read data of slot rd_a_reg valid
    logic [AW-1:0] rd_a_reg;
    logic          found_reg;
    logic [AW-1:0] found_a_reg;
    logic          hit_reg;
    logic [5:0]    best_reg;
    lpm_pkg::res_t res_reg;

    logic [CW-1:0] count_next;
    logic          we;
    logic [AW-1:0] wa;
    logic          match;

    assign cmd_ready = (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign out.valid = (state_reg == S_OUT);
    assign out.hit = res_reg.hit;
    assign out.next_hop_out = res_reg.next_hop_out;
    assign out.port_out = res_reg.port_out;
    assign out.table_full = res_reg.table_full;

    assign match = (cur_reg.op == lpm_pkg::OP_INSERT) ? (key_rd == {cur_reg.len, cur_reg.pfx})
        : ((cur_reg.pfx & lpm_pkg::len_mask(key_rd[37:32])) == key_rd[31:0]);

    always_comb
    begin
        we = 1'b0;
        wa = found_a_reg;
        count_next = count_reg;
        if (state_reg == S_FIN && cur_reg.op == lpm_pkg::OP_INSERT && !cur_reg.drop)
        begin
            if (found_reg)
                we = 1'b1;
            else if (count_reg < CW'(ROUTES))
            begin
                we = 1'b1;
                wa = count_reg[AW-1:0];
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_rd <= key_mem[idx_reg[AW-1:0]];
        tgt_rd <= tgt_mem[idx_reg[AW-1:0]];
        if (we)
        begin
            key_mem[wa] <= {cur_reg.len, cur_reg.pfx};
            tgt_mem[wa] <= {cur_reg.port, cur_reg.nh};
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd_valid)
            cur_reg <= cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg <= '0;
            rd_v_reg <= 1'b0;
            rd_a_reg <= '0;
            found_reg <= 1'b0;
            found_a_reg <= '0;
            hit_reg <= 1'b0;
            best_reg <= '0;
            res_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        state_reg <= S_SCAN;
                        idx_reg <= '0;
                        rd_v_reg <= 1'b0;
                        found_reg <= 1'b0;
                        hit_reg <= 1'b0;
                        best_reg <= '0;
                        res_reg <= '0;
                    end
                end
                S_SCAN:
                begin
                    // slot idx_reg is read this cycle, result seen next cycle
                    rd_v_reg <= (idx_reg < count_reg);
                    rd_a_reg <= idx_reg[AW-1:0];
                    if (idx_reg < count_reg)
                        idx_reg <= idx_reg + 1'b1;
                    if (rd_v_reg && match)
                    begin
                        if (cur_reg.op == lpm_pkg::OP_INSERT)
                        begin
                            if (!found_reg)
                            begin
                                found_reg <= 1'b1;
                                found_a_reg <= rd_a_reg;
                            end
                        end
                        else if (!hit_reg || key_rd[37:32] > best_reg)
                        begin
                            hit_reg <= 1'b1;
                            best_reg <= key_rd[37:32];
                            res_reg.hit <= 1'b1;
                            res_reg.next_hop_out <= tgt_rd[31:0];
                            res_reg.port_out <= tgt_rd[35:32];
                        end
                    end
                    if (!rd_v_reg && !(idx_reg < count_reg))
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (cur_reg.op == lpm_pkg::OP_INSERT && !cur_reg.drop && !found_reg
                        && !(count_reg < CW'(ROUTES)))
                        res_reg.table_full <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out.ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- src/longest_prefix_match_table.sv -----
// Flow: the front queue holds the transaction, the back end takes it when idle,
//   scans the occupied slots (one slot per cycle), then finishes and shows the result.
// The back end takes no new command until its result is taken; a 2-entry queue
//   lets the input accept while the back end works.
// Reset: route count cleared, table empty; memories are not cleared.
// ----------------------------------------------------------------------------
// longest_prefix_match_table
// IPv4 routing table with insert and longest prefix match lookup.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module longest_prefix_match_table #(
    parameter int ROUTES = lpm_pkg::ROUTES_DEF,
    parameter int PORTS  = lpm_pkg::PORTS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    lpm_in_if.sink    in,
    lpm_out_if.source out
);
    logic          cmd_valid, cmd_ready, busy;
    lpm_pkg::cmd_t cmd;

    lpm_front #(.PORTS(PORTS)) u_front (
        .clk(clk), .rst_n(rst_n), .in(in),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
    );

    lpm_back #(.ROUTES(ROUTES)) u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .out(out), .busy(busy)
    );

    `ASSERT_IMPLIES(a_lookup_not_full, out.valid && cmd_valid && !cmd_ready, busy)
    `ASSERT_IMPLIES(a_miss_zero, out.valid && !out.hit,
                    out.next_hop_out == 32'd0 && out.port_out == 4'd0)
    `ASSERT_IMPLIES(a_hit_not_full, out.valid && out.hit, !out.table_full)
    `ASSERT_NEXT(a_out_done, out.valid && out.ready, !out.valid)
endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// IPv4 longest prefix match table testbench
// Drives route inserts and address lookups with random stalls on both
// channels, predicts each result from a behavioral route list, and compares
// every result field in order.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_ROUTES   = lpm_pkg::ROUTES_DEF;
    localparam int NUM_PORTS    = lpm_pkg::PORTS_DEF;
    localparam int STALL_LIMIT  = 50000;
    localparam int DRAIN_CYCLES = NUM_ROUTES + 100;
    localparam int POOL_SIZE    = 48;

    typedef struct {
        logic        op;
        logic [31:0] prefix;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [3:0]  port;
        logic [31:0] addr;
    } request_t;

    class route_scoreboard;
        typedef struct {
            logic [5:0]  len;
            logic [31:0] pfx;
            logic [31:0] gateway;
            logic [3:0]  port;
        } route_t;

        route_t        routes[$];
        lpm_pkg::res_t expected_q[$];
        int            errors;
        int            inserts;
        int            lookups;
        int            hits;
        int            drops;

        function automatic logic [31:0] mask_of(logic [5:0] len);
            return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
        endfunction

        function int route_count();
            return routes.size();
        endfunction

        function void note(request_t req);
            lpm_pkg::res_t r;
            route_t        e;
            logic [5:0]    len;
            logic [31:0]   m;
            int            best;
            bit            found;
            r = '0;
            if (req.op == lpm_pkg::OP_INSERT)
            begin
                inserts++;
                len = 0;
                m = req.mask;
                while (m[31] && len < 32)
                begin
                    len++;
                    m = m << 1;
                end
                e.len = len;
                e.pfx = req.prefix & mask_of(len);
                e.gateway = req.gateway;
                e.port = req.port;
                found = 0;
                if (int'(req.port) < NUM_PORTS)
                begin
                    foreach (routes[i])
                    begin
                        if (!found && routes[i].len == e.len && routes[i].pfx == e.pfx)
                        begin
                            routes[i] = e;
                            found = 1;
                        end
                    end
                    if (!found)
                    begin
                        if (routes.size() < NUM_ROUTES)
                            routes.push_back(e);
                        else
                        begin
                            r.table_full = 1'b1;
                            drops++;
                        end
                    end
                end
            end
            else
            begin
                lookups++;
                best = -1;
                foreach (routes[i])
                begin
                    if ((req.addr & mask_of(routes[i].len)) == routes[i].pfx)
                    begin
                        if (best < 0 || routes[i].len > routes[best].len)
                            best = i;
                    end
                end
                if (best >= 0)
                begin
                    hits++;
                    r.hit = 1'b1;
                    r.next_hop_out = routes[best].gateway;
                    r.port_out = routes[best].port;
                end
            end
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check(lpm_pkg::res_t got);
            lpm_pkg::res_t exp_r;
            if (expected_q.size() == 0)
                report($sformatf("result with nothing expected: %p", got));
            else
            begin
                exp_r = expected_q.pop_front();
                if (got.hit !== exp_r.hit)
                    report($sformatf("hit %b, expected %b", got.hit, exp_r.hit));
                if (got.next_hop_out !== exp_r.next_hop_out)
                    report($sformatf("next_hop_out %h, expected %h",
                                     got.next_hop_out, exp_r.next_hop_out));
                if (got.port_out !== exp_r.port_out)
                    report($sformatf("port_out %h, expected %h",
                                     got.port_out, exp_r.port_out));
                if (got.table_full !== exp_r.table_full)
                    report($sformatf("table_full %b, expected %b",
                                     got.table_full, exp_r.table_full));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;

    lpm_in_if  in_ch();
    lpm_out_if out_ch();

    longest_prefix_match_table u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch.sink),
        .out   (out_ch.source)
    );

    route_scoreboard routes_sb = new();

    int unsigned src_idle;
    int unsigned snk_idle;
    bit          hold_req;
    int          quiet_cycles;

    logic [31:0] pool_pfx[POOL_SIZE];
    logic [5:0]  pool_len[POOL_SIZE];

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.op = lpm_pkg::OP_INSERT;
        in_ch.route_prefix = '0;
        in_ch.route_mask = '0;
        in_ch.next_hop_in = '0;
        in_ch.port_in = '0;
        in_ch.lookup_addr = '0;
        out_ch.ready = 1'b0;
    end

    always #5 clk = ~clk;

    // watchdog: cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("Watchdog expired after %0d idle cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side
    initial
    begin
        lpm_pkg::res_t got;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_req = 0;
            end
            out_ch.ready <= ($urandom_range(99) >= snk_idle);
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                got.hit = out_ch.hit;
                got.next_hop_out = out_ch.next_hop_out;
                got.port_out = out_ch.port_out;
                got.table_full = out_ch.table_full;
                routes_sb.check(got);
            end
        end
    end

    task automatic send(request_t req);
        if ($urandom_range(99) < src_idle)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op <= req.op;
        in_ch.route_prefix <= req.prefix;
        in_ch.route_mask <= req.mask;
        in_ch.next_hop_in <= req.gateway;
        in_ch.port_in <= req.port;
        in_ch.lookup_addr <= req.addr;
        do
            @(posedge clk);
        while (!in_ch.ready);
        routes_sb.note(req);
    endtask

    function automatic logic [31:0] ones(int len);
        return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
    endfunction

    // mask of the given length, optionally with stray ones past the first zero
    function automatic logic [31:0] mask_for(int len, bit noisy);
        logic [31:0] m;
        m = ones(len);
        if (noisy && len < 31)
            m = m | ($urandom & ~m & ~(32'h8000_0000 >> len));
        return m;
    endfunction

    task automatic insert(logic [31:0] pfx, logic [31:0] mask,
                          logic [31:0] nh, logic [3:0] port);
        request_t req;
        req.op = lpm_pkg::OP_INSERT;
        req.prefix = pfx;
        req.mask = mask;
        req.gateway = nh;
        req.port = port;
        req.addr = $urandom;
        send(req);
    endtask

    task automatic lookup(logic [31:0] addr);
        request_t req;
        req.op = lpm_pkg::OP_LOOKUP;
        req.prefix = $urandom;
        req.mask = $urandom;
        req.gateway = $urandom;
        req.port = 4'($urandom);
        req.addr = addr;
        send(req);
    endtask

    task automatic random_item();
        int k;
        int len;
        k = $urandom_range(POOL_SIZE - 1);
        case ($urandom_range(9))
            0, 1, 2:
                insert(pool_pfx[k] | ($urandom & ~ones(pool_len[k])),
                       mask_for(pool_len[k], $urandom_range(1)), $urandom, 4'($urandom));
            3:
            begin
                len = $urandom_range(32);
                if (routes_sb.route_count() < 150)
                    insert($urandom, mask_for(len, $urandom_range(1)), $urandom,
                           4'($urandom));
                else
                    lookup($urandom);
            end
            4, 5:
                lookup($urandom);
            default:
                lookup(pool_pfx[k] | ($urandom & ~ones(pool_len[k])));
        endcase
    endtask

    task automatic wait_drain();
        int n;
        n = 0;
        while (routes_sb.expected_q.size() != 0 && n < STALL_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int n;
        src_idle = 0;
        snk_idle = 0;
        hold_req = 0;
        quiet_cycles = 0;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_len[i] = (i == 0) ? 6'd32 : (i == 1) ? 6'd0 : 6'($urandom_range(32));
            pool_pfx[i] = $urandom & ones(pool_len[i]);
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, default route, host route, overlaps, noise mask
        lookup(32'h0);
        lookup(32'hFFFF_FFFF);
        insert(32'hDEAD_BEEF, 32'h0000_0000, 32'h0A00_0001, 4'd0);
        lookup(32'h1234_5678);
        insert(32'hC0A8_0107, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
        insert(32'hC0A8_01FF, 32'hFFFF_FF00, 32'h0A00_0002, 4'd2);
        insert(32'hC0FF_FFFF, 32'hFF00_F0F1, 32'h0A00_0003, 4'd3);
        insert(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h0000_0000, 4'd7);
        lookup(32'hC0A8_0107);
        lookup(32'hC0A8_0106);
        lookup(32'hC012_3456);
        lookup(32'hFFFF_FFFF);
        lookup(32'hFFFF_FFFE);
        lookup(32'h0000_0000);
        insert(32'hC0A8_0100, 32'hFFFF_FF00, 32'h0B00_0002, 4'd9);
        insert(32'h0000_0000, 32'h7FFF_FFFF, 32'h0C00_0001, 4'd1);
        lookup(32'hC0A8_0155);
        lookup(32'h5555_5555);

        // random, three stall mixes
        src_idle = 33;
        snk_idle = 79;
        for (n = 0; n < 250; n++)
            random_item();
        src_idle = 79;
        snk_idle = 33;
        for (n = 0; n < 250; n++)
            random_item();
        src_idle = 0;
        snk_idle = 0;
        hold_req = 1;
        for (n = 0; n < 260; n++)
            random_item();

        // fill the table, then overflow it
        n = 0;
        while (routes_sb.route_count() < NUM_ROUTES)
        begin
            insert(32'h0A00_0000 + n, 32'hFFFF_FFFF, $urandom, 4'($urandom));
            n++;
        end
        for (int i = 0; i < 4; i++)
            insert($urandom, mask_for($urandom_range(1, 20), 1), $urandom, 4'($urandom));
        insert(32'hC0A8_0107, 32'hFFFF_FFFF, 32'h0D00_0001, 4'd4);
        insert(32'h0A00_0000, 32'hFFFF_FFFF, 32'h0D00_0002, 4'd5);
        lookup(32'h0A00_0000);
        lookup(32'hC0A8_0107);
        lookup(32'h0A00_0000 + n - 1);
        lookup($urandom);
        in_ch.valid <= 1'b0;

        wait_drain();
        $display("Covered %0d inserts (%0d dropped on a full table), %0d lookups (%0d hits).",
                 routes_sb.inserts, routes_sb.drops, routes_sb.lookups, routes_sb.hits);
        $display("Routes held at end: %0d, results outstanding: %0d.",
                 routes_sb.route_count(), routes_sb.expected_q.size());
        if (routes_sb.errors == 0 && routes_sb.expected_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
